@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file, tdd_checker.sv.
// Each macro expands to one labeled concurrent assertion reported by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define AST_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off while reset is asserted.
`define AST_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also checks across reset.
`define AST_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/tdd_pkg.sv @@
// Package for the trace deadband decimator: widths, register codes, types.
// Used by every file under rtl/core but assert_macros.svh; depends on nothing.
package tdd_pkg;

  localparam int TIME_W      = 32;
  localparam int VOLT_W      = 16;
  localparam int REL_W       = 34;
  localparam int ORIGIN_W    = 33;
  localparam int STEP_W      = 16;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd1000000;
  localparam logic [TIME_W-1:0] OFFSET_RESET = 32'd0;
  localparam logic [STEP_W-1:0] STEP_RESET   = 16'd256;
  localparam logic [TIME_W-1:0] GAP_RESET    = 32'd10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH   = 3'd0,
    CFG_START_OFFSET    = 3'd1,
    CFG_VOLTAGE_STEP    = 3'd2,
    CFG_TIME_GAP        = 3'd3,
    CFG_THINNING_ENABLE = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [TIME_W-1:0] window_length;
    logic [TIME_W-1:0] start_offset;
    logic [STEP_W-1:0] voltage_step;
    logic [TIME_W-1:0] time_gap;
    logic              thinning_enable;
  } cfg_t;

  // One queue entry: the kept sample, preceded by the held-back prior when two is set.
  typedef struct packed {
    logic                     two;
    logic signed [REL_W-1:0]  prior_rel;
    logic signed [VOLT_W-1:0] prior_voltage;
    logic signed [REL_W-1:0]  cur_rel;
    logic signed [VOLT_W-1:0] cur_voltage;
  } entry_t;

endpackage

@@ rtl/core/tdd_in_if.sv @@
// Sample channel of the trace deadband decimator: valid/ready plus sample fields.
// Depends on tdd_pkg.
interface tdd_in_if;
  logic                              valid;
  logic                              ready;
  logic [tdd_pkg::TIME_W-1:0]        sample_time;
  logic signed [tdd_pkg::VOLT_W-1:0] sample_voltage;
  logic                              trace_start;

  modport source (output valid, output sample_time, output sample_voltage,
                  output trace_start, input ready);
  modport sink   (input valid, input sample_time, input sample_voltage,
                  input trace_start, output ready);
endinterface

@@ rtl/core/tdd_out_if.sv @@
// Result channel of the trace deadband decimator: valid/ready plus result fields.
// Depends on tdd_pkg.
interface tdd_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [tdd_pkg::REL_W-1:0]  rel_time;
  logic signed [tdd_pkg::VOLT_W-1:0] out_voltage;
  logic                              last_of_run;

  modport source (output valid, output rel_time, output out_voltage,
                  output last_of_run, input ready);
  modport sink   (input valid, input rel_time, input out_voltage,
                  input last_of_run, output ready);
endinterface

@@ rtl/core/tdd_front.sv @@
// Front end: accepts samples, tracks trace state, decides keep/skip/window stop.
// Pushes one queue entry per kept sample. Depends on tdd_pkg, tdd_in_if.
module tdd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  tdd_pkg::cfg_t       cfg,
  tdd_in_if.sink              in_ch,
  input  logic                q_ready,
  output logic                push,
  output tdd_pkg::entry_t     push_entry
);

  localparam int TW = tdd_pkg::TIME_W;
  localparam int VW = tdd_pkg::VOLT_W;
  localparam int RW = tdd_pkg::REL_W;
  localparam int OW = tdd_pkg::ORIGIN_W;

  logic [OW-1:0]        origin_r, origin_nxt;
  logic signed [VW-1:0] kept_v_r, kept_v_nxt;
  logic [TW-1:0]        kept_t_r, kept_t_nxt;
  logic [TW-1:0]        prior_t_r, prior_t_nxt;
  logic signed [VW-1:0] prior_v_r, prior_v_nxt;
  logic                 pwe_r, pwe_nxt;
  logic                 done_r, done_nxt;
  logic                 open_r, open_nxt;

  logic                 accept;
  logic                 first;
  logic                 done_eff;
  logic [TW-1:0]        t;
  logic signed [VW-1:0] v;
  logic signed [RW-1:0] rel_run, rel_first, cur_rel, prior_rel;
  logic                 past_window;
  logic signed [VW:0]   dv, dv_abs;
  logic                 over_step;
  logic signed [TW:0]   dt;
  logic                 over_gap;
  logic                 keep_volt, keep_gap;

  always_comb begin
    t           = in_ch.sample_time;
    v           = in_ch.sample_voltage;
    in_ch.ready = q_ready;
    accept      = in_ch.valid && q_ready;
    first       = in_ch.trace_start || !open_r;
    done_eff    = first ? 1'b0 : done_r;

    // On a trace start, t - (t + offset) is just -offset.
    rel_run     = $signed({2'b00, t} - {1'b0, origin_r});
    rel_first   = $signed(RW'(0) - {2'b00, cfg.start_offset});
    cur_rel     = first ? rel_first : rel_run;
    prior_rel   = $signed({2'b00, prior_t_r} - {1'b0, origin_r});
    past_window = cur_rel > $signed({2'b00, cfg.window_length});

    dv        = $signed({v[VW-1], v}) - $signed({kept_v_r[VW-1], kept_v_r});
    dv_abs    = dv[VW] ? -dv : dv;
    over_step = $unsigned(dv_abs) > {1'b0, cfg.voltage_step};
    dt        = $signed({1'b0, t}) - $signed({1'b0, kept_t_r});
    over_gap  = dt > $signed({1'b0, cfg.time_gap});
    keep_volt = !first && over_step;
    keep_gap  = !first && !over_step && over_gap;
  end

  always_comb begin
    origin_nxt  = origin_r;
    kept_v_nxt  = kept_v_r;
    kept_t_nxt  = kept_t_r;
    prior_t_nxt = prior_t_r;
    prior_v_nxt = prior_v_r;
    pwe_nxt     = pwe_r;
    done_nxt    = done_r;
    open_nxt    = open_r;
    push        = 1'b0;

    push_entry.two           = 1'b0;
    push_entry.prior_rel     = prior_rel;
    push_entry.prior_voltage = prior_v_r;
    push_entry.cur_rel       = cur_rel;
    push_entry.cur_voltage   = v;

    if (accept) begin
      if (first) begin
        origin_nxt = OW'({1'b0, t} + {1'b0, cfg.start_offset});
        done_nxt   = 1'b0;
        open_nxt   = 1'b1;
        pwe_nxt    = 1'b1;
        kept_v_nxt = v;
        kept_t_nxt = t;
      end
      if (!done_eff) begin
        if (past_window) begin
          done_nxt = 1'b1;
        end else if (cfg.thinning_enable) begin
          prior_t_nxt = t;
          prior_v_nxt = v;
          if (first || keep_volt || keep_gap) begin
            // A voltage keep after skipped samples re-emits the last skipped one.
            push_entry.two = keep_volt && !pwe_r;
            push           = 1'b1;
            pwe_nxt        = 1'b1;
            kept_v_nxt     = v;
            kept_t_nxt     = t;
          end else begin
            pwe_nxt = 1'b0;
          end
        end else begin
          push        = 1'b1;
          prior_t_nxt = t;
          prior_v_nxt = v;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r  <= '0;
      kept_v_r  <= '0;
      kept_t_r  <= '0;
      prior_t_r <= '0;
      prior_v_r <= '0;
      pwe_r     <= 1'b1;
      done_r    <= 1'b0;
      open_r    <= 1'b0;
    end else begin
      origin_r  <= origin_nxt;
      kept_v_r  <= kept_v_nxt;
      kept_t_r  <= kept_t_nxt;
      prior_t_r <= prior_t_nxt;
      prior_v_r <= prior_v_nxt;
      pwe_r     <= pwe_nxt;
      done_r    <= done_nxt;
      open_r    <= open_nxt;
    end
  end

endmodule

@@ rtl/core/tdd_queue.sv @@
// Small register FIFO of emit entries between the front and back ends.
// Depends on tdd_pkg.
module tdd_queue #(
  parameter int Depth = tdd_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tdd_pkg::entry_t push_entry,
  output logic            ready,
  input  logic            pop,
  output logic            valid,
  output tdd_pkg::entry_t head
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  tdd_pkg::entry_t entries_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  always_comb begin
    ready = count_r != CntW'(Depth);
    valid = count_r != '0;
    head  = entries_r[rd_ptr_r];

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ rtl/core/tdd_back.sv @@
// Back end: drains queue entries onto the result channel, one or two results each.
// Depends on tdd_pkg, tdd_out_if.
module tdd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  tdd_pkg::entry_t head,
  output logic            pop,
  tdd_out_if.source       out_ch
);

  logic phase_r, phase_nxt;  // set once the prior half of a two-result entry is out
  logic send_prior;
  logic xfer;

  always_comb begin
    send_prior         = head.two && !phase_r;
    out_ch.valid       = q_valid;
    out_ch.rel_time    = send_prior ? head.prior_rel : head.cur_rel;
    out_ch.out_voltage = send_prior ? head.prior_voltage : head.cur_voltage;
    out_ch.last_of_run = !send_prior;
    xfer               = q_valid && out_ch.ready;
    pop                = xfer && !send_prior;
    phase_nxt          = phase_r;
    if (xfer) begin
      phase_nxt = send_prior;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

endmodule

@@ rtl/core/trace_deadband_decimator.sv @@
// Top level of the trace deadband decimator: config registers, front, queue, back.
// Depends on tdd_pkg, tdd_in_if, tdd_out_if, tdd_front, tdd_queue, tdd_back.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    sample_time, sample_voltage, trace_start
//   out_ch   out  valid/ready    rel_time, out_voltage, last_of_run
//   cfg_*    in   cfg_we only    cfg_index, cfg_data
//
// One sample is taken every cycle while the emit queue has room; the front
// decides keep/skip in the cycle of the transfer.
// A kept sample is registered in the queue and leaves from there; an entry with a
// re-emitted prior gives two results, so bursts of those fill the queue.
// in_ch.ready depends only on queue fill, never on out_ch.ready in the same cycle.
// Reset is synchronous; config returns to its defaults and the queue empties.
module trace_deadband_decimator #(
  parameter int QueueDepth = tdd_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  tdd_in_if.sink                            in_ch,
  tdd_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [tdd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tdd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  tdd_pkg::cfg_t   cfg_r, cfg_nxt;
  logic            q_ready, q_valid, push, pop;
  tdd_pkg::entry_t push_entry, head;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (tdd_pkg::cfg_idx_t'(cfg_index))
        tdd_pkg::CFG_WINDOW_LENGTH:   cfg_nxt.window_length   = cfg_data;
        tdd_pkg::CFG_START_OFFSET:    cfg_nxt.start_offset    = cfg_data;
        tdd_pkg::CFG_VOLTAGE_STEP:    cfg_nxt.voltage_step    =
                                        cfg_data[tdd_pkg::STEP_W-1:0];
        tdd_pkg::CFG_TIME_GAP:        cfg_nxt.time_gap        = cfg_data;
        tdd_pkg::CFG_THINNING_ENABLE: cfg_nxt.thinning_enable = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_length   <= tdd_pkg::WINDOW_RESET;
      cfg_r.start_offset    <= tdd_pkg::OFFSET_RESET;
      cfg_r.voltage_step    <= tdd_pkg::STEP_RESET;
      cfg_r.time_gap        <= tdd_pkg::GAP_RESET;
      cfg_r.thinning_enable <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tdd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_ch      (in_ch),
    .q_ready    (q_ready),
    .push       (push),
    .push_entry (push_entry)
  );

  tdd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .ready      (q_ready),
    .pop        (pop),
    .valid      (q_valid),
    .head       (head)
  );

  tdd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .head    (head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

@@ rtl/core/tdd_checker.sv @@
// Port-level checker for trace_deadband_decimator, attached by bind below.
// Depends on assert_macros.svh and tdd_pkg.
`include "assert_macros.svh"

module tdd_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [tdd_pkg::REL_W-1:0]         out_rel_time,
  input logic [tdd_pkg::VOLT_W-1:0]        out_voltage,
  input logic                              out_last
);

  logic out_xfer;
  assign out_xfer = out_valid && out_ready;

  // A stalled result holds its payload.
  `AST_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_rel_time) && $stable(out_voltage) && $stable(out_last))
  // The re-emitted prior is followed at once by the sample that caused it.
  `AST_NEXT(a_pair_follows, clk, rst_n, out_xfer && !out_last, out_valid && out_last)
  // A single input never produces two non-final results in a row.
  `AST_IMPL(a_no_double_prior, clk, rst_n, out_xfer && !out_last && $past(out_xfer && !out_last), 1'b0)
  // Reset empties the queue and opens the input.
  `AST_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid && in_ready)

endmodule

bind trace_deadband_decimator tdd_checker u_tdd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_rel_time (out_ch.rel_time),
  .out_voltage  (out_ch.out_voltage),
  .out_last     (out_ch.last_of_run)
);

@@ test/testbench.sv @@
// Testbench for trace_deadband_decimator: directed and random sample traces,
// checked against a local deadband/max-interval predictor.
// Depends on tdd_pkg, tdd_in_if, tdd_out_if and the RTL top level.
`timescale 1ns / 100ps

module testbench;
  import tdd_pkg::*;

  localparam int SETTLE_CYCLES = 4;
  localparam int QUIET_LIMIT   = 4000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 105;

  typedef struct packed {
    logic [REL_W-1:0]  rel_time;
    logic [VOLT_W-1:0] voltage;
    logic              last;
  } emitted_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tdd_in_if  in_if();
  tdd_out_if out_if();

  trace_deadband_decimator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor copy of the registers
  logic [TIME_W-1:0] window_length;
  logic [TIME_W-1:0] start_offset;
  logic [STEP_W-1:0] voltage_step;
  logic [TIME_W-1:0] time_gap;
  logic              thin_en;

  // Predictor copy of the trace state
  logic [ORIGIN_W-1:0]      origin_time;
  logic signed [VOLT_W-1:0] kept_voltage;
  logic [TIME_W-1:0]        kept_time;
  logic [TIME_W-1:0]        prior_time;
  logic signed [VOLT_W-1:0] prior_voltage;
  logic                     prior_emitted;
  logic                     window_done;
  logic                     trace_open;

  emitted_t pending_emits[$];

  bit idle_on;
  int errors;
  int items_sent;
  int results_checked;
  int reemits_seen;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void reset_predictor();
    window_length = WINDOW_RESET;
    start_offset  = OFFSET_RESET;
    voltage_step  = STEP_RESET;
    time_gap      = GAP_RESET;
    thin_en       = 1'b1;
    origin_time   = '0;
    kept_voltage  = '0;
    kept_time     = '0;
    prior_time    = '0;
    prior_voltage = '0;
    prior_emitted = 1'b1;
    window_done   = 1'b0;
    trace_open    = 1'b0;
  endfunction

  function automatic void queue_emit(input logic [TIME_W-1:0] t,
                                     input logic signed [VOLT_W-1:0] v, input logic last);
    longint rel;
    emitted_t e;
    rel = longint'(t) - longint'(origin_time);
    e.rel_time = rel[REL_W-1:0];
    e.voltage  = v;
    e.last     = last;
    pending_emits.push_back(e);
  endfunction

  // Works out what one accepted sample emits, in order.
  function automatic void predict_emits(input logic [TIME_W-1:0] t,
                                        input logic signed [VOLT_W-1:0] v, input logic st);
    logic first;
    int   dv;
    first = st || !trace_open;
    if (first) begin
      origin_time   = {1'b0, t} + {1'b0, start_offset};
      window_done   = 1'b0;
      trace_open    = 1'b1;
      prior_emitted = 1'b1;
      kept_voltage  = v;
      kept_time     = t;
    end
    if (window_done)
      return;
    if (longint'(t) - longint'(origin_time) > longint'(window_length)) begin
      window_done = 1'b1;
      return;
    end
    if (thin_en) begin
      if (!first) begin
        dv = int'(v) - int'(kept_voltage);
        if (dv < 0)
          dv = -dv;
        if (dv <= int'(voltage_step)) begin
          // time signed: a step backward never exceeds the gap
          if (longint'(t) - longint'(kept_time) > longint'(time_gap)) begin
            prior_emitted = 1'b1;
          end else begin
            prior_emitted = 1'b0;
            prior_time    = t;
            prior_voltage = v;
            return;
          end
        end
      end
      if (!prior_emitted)
        queue_emit(prior_time, prior_voltage, 1'b0);
      prior_emitted = 1'b1;
      kept_voltage  = v;
      kept_time     = t;
    end
    queue_emit(t, v, 1'b1);
    prior_time    = t;
    prior_voltage = v;
  endfunction

  // Result checker
  always @(posedge clk) begin : check_emits
    emitted_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_emits.size() == 0) begin
        $error("result with none pending: rel_time=%0h out_voltage=%0h last_of_run=%0b",
               out_if.rel_time, out_if.out_voltage, out_if.last_of_run);
        errors++;
      end else begin
        want = pending_emits.pop_front();
        results_checked++;
        if (!want.last)
          reemits_seen++;
        if (out_if.rel_time !== want.rel_time) begin
          $error("rel_time: expected %0h, got %0h", want.rel_time, out_if.rel_time);
          errors++;
        end
        if (out_if.out_voltage !== want.voltage) begin
          $error("out_voltage: expected %0h, got %0h", want.voltage, out_if.out_voltage);
          errors++;
        end
        if (out_if.last_of_run !== want.last) begin
          $error("last_of_run: expected %0b, got %0b", want.last, out_if.last_of_run);
          errors++;
        end
      end
    end
  end

  // Result-side stalls
  always @(negedge clk)
    out_if.ready <= !idle_on || ($urandom_range(99) >= 17);

  // Watchdog: no transfer on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[trace_deadband_decimator] ERROR");
        $finish;
      end
    end
  end

  // Entered and left at a falling edge.
  task automatic send_sample(input logic [TIME_W-1:0] t, input logic [VOLT_W-1:0] v,
                             input logic st);
    if (idle_on && $urandom_range(99) < 20) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid          = 1'b1;
    in_if.sample_time    = t;
    in_if.sample_voltage = v;
    in_if.trace_start    = st;
    @(posedge clk);
    while (!in_if.ready)
      @(posedge clk);
    predict_emits(t, v, st);
    items_sent++;
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  // Hold the sender until every pending result has come out and the front is empty.
  task automatic wait_for_emits();
    in_if.valid = 1'b0;
    while (pending_emits.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    case (idx)
      CFG_WINDOW_LENGTH:   window_length = value;
      CFG_START_OFFSET:    start_offset  = value;
      CFG_VOLTAGE_STEP:    voltage_step  = value[STEP_W-1:0];
      CFG_TIME_GAP:        time_gap      = value;
      CFG_THINNING_ENABLE: thin_en       = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_config(input logic [31:0] win, input logic [31:0] offs,
                            input logic [15:0] step, input logic [31:0] gap, input logic th);
    wait_for_emits();
    write_reg(CFG_WINDOW_LENGTH, win);
    write_reg(CFG_START_OFFSET, offs);
    write_reg(CFG_VOLTAGE_STEP, {16'd0, step});
    write_reg(CFG_TIME_GAP, gap);
    write_reg(CFG_THINNING_ENABLE, {31'd0, th});
  endtask

  // Reset register values: deadband edges, re-emit, time reason, window, wrap
  task automatic test_default_deadband();
    send_sample(32'd1000, 16'sd0, 1'b0);        // no open trace yet
    send_sample(32'd1010, 16'sd100, 1'b0);
    send_sample(32'd1020, 16'sd256, 1'b0);      // equal to step: skipped
    send_sample(32'd1030, 16'sd300, 1'b0);      // re-emits the one before
    send_sample(32'd11030, 16'sd300, 1'b0);     // gap exactly equal: skipped
    send_sample(32'd11031, 16'sd200, 1'b0);     // kept on time
    send_sample(32'd11000, 16'sd300, 1'b0);     // time backward
    send_sample(32'd11040, 16'h8000, 1'b0);
    send_sample(32'd11050, 16'h7FFF, 1'b0);
    send_sample(32'd1001000, 16'h7FFF, 1'b0);   // rel_time on the window edge
    send_sample(32'd1001001, 16'sd0, 1'b0);     // past the window
    send_sample(32'd1001002, -16'sd100, 1'b0);
    send_sample(32'hFFFF_FFFF, 16'h7FFF, 1'b1);
    send_sample(32'd0, 16'sd0, 1'b0);           // negative rel_time
    send_sample(32'd5, 16'sd0, 1'b1);
  endtask

  task automatic test_register_extremes();
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 32'd0, 1'b0);
    send_sample(32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    send_sample(32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    wait_for_emits();
    write_reg(CFG_THINNING_ENABLE, 32'd1);
    send_sample(32'hFFFF_FFFF, 16'hFFFF, 1'b0); // zero deadband, no change: skipped
    send_sample(32'hFFFF_FFFF, 16'h0000, 1'b0);
    set_config(32'd0, 32'd0, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send_sample(32'd100, 16'h8000, 1'b1);
    send_sample(32'd100, 16'h7FFF, 1'b0);       // full-scale swing stays in deadband
    send_sample(32'd101, 16'h0000, 1'b0);
    send_sample(32'd100, 16'h0000, 1'b0);
    set_config(32'd5, 32'd0, 16'd256, 32'd10000, 1'b0);
    send_sample(32'd200, 16'sd1, 1'b1);
    send_sample(32'd203, 16'sd1, 1'b0);
    send_sample(32'd210, 16'sd1, 1'b0);
  endtask

  // Mostly nondecreasing traces with steps around the deadband, plus noise.
  task automatic test_random_traces();
    logic [31:0]       win, offs, gap, t;
    logic [15:0]       step;
    logic signed [15:0] v;
    logic              th, st;
    int vscale, tscale, trace_left, kind, v_next;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) begin
        win = WINDOW_RESET; offs = OFFSET_RESET; step = STEP_RESET; gap = GAP_RESET; th = 1'b1;
      end else begin
        case ($urandom_range(3))
          0: step = 16'd0;
          1: step = 16'($urandom);
          default: step = 16'($urandom_range(1, 2000));
        endcase
        case ($urandom_range(3))
          0: gap = 32'd0;
          1: gap = 32'hFFFF_FFFF;
          default: gap = $urandom_range(1, 30000);
        endcase
        th = ($urandom_range(4) != 0);
      end
      tscale = (gap > 32'd20000) ? 10000 : int'(gap) / 2 + 2;
      vscale = (step > 16'd8000) ? 16000 : 2 * int'(step) + 4;
      if (p != 0) begin
        win = (p == 3) ? 32'hFFFF_FFFF : $urandom_range(tscale * 4, tscale * 40);
        case ($urandom_range(9))
          0: offs = $urandom;
          1, 2, 3: offs = $urandom_range(0, tscale * 4);
          default: offs = 32'd0;
        endcase
      end
      idle_on = (p != 1);
      set_config(win, offs, step, gap, th);
      trace_left = 0;
      t = '0;
      v = '0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2)
          wait_for_emits();
        st = 1'b0;
        if (trace_left == 0) begin
          trace_left = $urandom_range(3, 40);
          t  = $urandom;
          v  = 16'($urandom);
          st = ($urandom_range(9) != 0);
        end else begin
          trace_left--;
          kind = $urandom_range(99);
          if (kind < 86) begin
            t = t + $urandom_range(0, tscale);
            v_next = int'(v) + int'($urandom_range(0, 2 * vscale)) - vscale;
            v = v_next[15:0];
          end else if (kind < 93) begin
            t = t - $urandom_range(0, 1000);
          end else if (kind < 97) begin
            v = 16'($urandom);
          end else begin
            st = 1'b1;
          end
        end
        send_sample(t, v, st);
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = CFG_WINDOW_LENGTH;
    cfg_data             = '0;
    in_if.valid          = 1'b0;
    in_if.sample_time    = '0;
    in_if.sample_voltage = '0;
    in_if.trace_start    = 1'b0;
    out_if.ready         = 1'b1;
    idle_on              = 1'b1;
    errors               = 0;
    items_sent           = 0;
    results_checked      = 0;
    reemits_seen         = 0;
    quiet_cycles         = 0;
    reset_predictor();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_default_deadband();
    test_register_extremes();
    test_random_traces();
    wait_for_emits();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (pending_emits.size() != 0) begin
      $error("%0d expected results never came out", pending_emits.size());
      errors++;
    end
    $display("Sent %0d samples; %0d results checked, %0d of them held-back samples.",
             items_sent, results_checked, reemits_seen);
    $display("Covered reset and extreme registers plus %0d random register sets.",
             RANDOM_PHASES - 1);
    if (errors == 0) begin
      $display("[trace_deadband_decimator] OK");
    end else begin
      $display("[trace_deadband_decimator] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/tdd_pkg.sv
rtl/core/tdd_in_if.sv
rtl/core/tdd_out_if.sv
rtl/core/tdd_front.sv
rtl/core/tdd_queue.sv
rtl/core/tdd_back.sv
rtl/core/trace_deadband_decimator.sv
rtl/core/tdd_checker.sv
test/testbench.sv
